[sv/mtsu_pkg.sv]
// mtsu_pkg: shared types and constants for the mt19937 state seed and twist unit
// no dependencies; used by every module of the block and by its checker

package mtsu_pkg;

  // field widths of the ports
  localparam int DATA_W     = 32;
  localparam int INDEX_W    = 10;
  localparam int FUNC_W     = 2;
  localparam int IN_TDATA_W = 48;
  localparam int CFG_ADDR_W = 3;

  // register map: index of each register, byte address is 4 * index
  localparam logic [0:0] REG_DEFAULT_SEED = 1'b0;

  localparam logic [DATA_W-1:0] DEFAULT_SEED_RST = 32'd29;

  // twist recurrence constants
  localparam logic [DATA_W-1:0] TW_MATRIX = 32'h9908_b0df;
  localparam logic [DATA_W-1:0] TW_UPPER  = 32'h8000_0000;
  localparam logic [DATA_W-1:0] TW_LOWER  = 32'h7fff_ffff;

  // seed recurrence constants
  localparam logic [DATA_W-1:0] SEED_MULT  = 32'd1812433253;
  localparam int                SEED_SHIFT = 30;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SEED  = 2'd0,
    FUNC_TWIST = 2'd1,
    FUNC_READ  = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_TW_PRE,
    ST_TW_RUN,
    ST_TW_END,
    ST_RD_ISSUE,
    ST_RD_DATA
  } seq_state_t;

  // sequencer to word unit control
  typedef struct packed {
    logic seed_step;
    logic seed_first;
    logic twist_prime;
    logic twist_comp;
  } unit_ctrl_t;

endpackage

[sv/mtsu_state_ram.sv]
// mtsu_state_ram: state word memory, one write port, two registered read ports
// read data bypasses a write that lands on the same edge; uses mtsu_pkg

module mtsu_state_ram #(
  parameter int DEPTH = 624,
  parameter int AW    = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [mtsu_pkg::DATA_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              ra0,
  input  logic [AW-1:0]              ra1,
  output logic [mtsu_pkg::DATA_W-1:0] rd0,
  output logic [mtsu_pkg::DATA_W-1:0] rd1
);

  logic [mtsu_pkg::DATA_W-1:0] mem [DEPTH];

  logic [AW-1:0]               ra0_r;
  logic [AW-1:0]               ra1_r;
  logic [mtsu_pkg::DATA_W-1:0] rd0_r;
  logic [mtsu_pkg::DATA_W-1:0] rd1_r;
  logic                        byp_v_r;
  logic [AW-1:0]               byp_a_r;
  logic [mtsu_pkg::DATA_W-1:0] byp_d_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd0_r   <= mem[ra0];
      rd1_r   <= mem[ra1];
      ra0_r   <= ra0;
      ra1_r   <= ra1;
      byp_a_r <= waddr;
      byp_d_r <= wdata;
    end
  end

  // write seen by the same read edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_v_r <= 1'b0;
    end else if (re) begin
      byp_v_r <= we;
    end
  end

  assign rd0 = (byp_v_r && (byp_a_r == ra0_r)) ? byp_d_r : rd0_r;
  assign rd1 = (byp_v_r && (byp_a_r == ra1_r)) ? byp_d_r : rd1_r;

endmodule

[sv/mtsu_word_unit.sv]
// mtsu_word_unit: shared datapath producing one new state word per cycle
// seed multiply-add or twist mix, selected by the sequencer; uses mtsu_pkg

module mtsu_word_unit #(
  parameter int AW = 10
) (
  input  logic                        clk,
  input  mtsu_pkg::unit_ctrl_t        ctrl,
  input  logic [AW-1:0]               idx,
  input  logic [mtsu_pkg::DATA_W-1:0] seed_base,
  input  logic [mtsu_pkg::DATA_W-1:0] rd0,
  input  logic [mtsu_pkg::DATA_W-1:0] rd1,
  output logic [mtsu_pkg::DATA_W-1:0] wdata
);

  logic [mtsu_pkg::DATA_W-1:0] prev_r;
  logic [mtsu_pkg::DATA_W-1:0] cur_r;
  logic [mtsu_pkg::DATA_W-1:0] mix;
  logic [mtsu_pkg::DATA_W-1:0] prod;
  logic [mtsu_pkg::DATA_W-1:0] seed_w;
  logic [mtsu_pkg::DATA_W-1:0] y;
  logic [mtsu_pkg::DATA_W-1:0] mag;
  logic [mtsu_pkg::DATA_W-1:0] twist_w;

  // seed: mult * (prev ^ (prev >> 30)) + index, low 32 bits
  assign mix    = prev_r ^ (prev_r >> mtsu_pkg::SEED_SHIFT);
  assign prod   = mtsu_pkg::SEED_MULT * mix;
  assign seed_w = ctrl.seed_first ? seed_base : prod + mtsu_pkg::DATA_W'(idx);

  // twist: rd0 is the next word, rd1 the far word
  assign y       = (cur_r & mtsu_pkg::TW_UPPER) | (rd0 & mtsu_pkg::TW_LOWER);
  assign mag     = y[0] ? mtsu_pkg::TW_MATRIX : '0;
  assign twist_w = rd1 ^ (y >> 1) ^ mag;

  assign wdata = ctrl.seed_step ? seed_w : twist_w;

  always_ff @(posedge clk) begin
    if (ctrl.seed_step) begin
      prev_r <= seed_w;
    end
    // old value of the next word becomes the current word
    if (ctrl.twist_prime || ctrl.twist_comp) begin
      cur_r <= rd0;
    end
  end

endmodule

[sv/mtsu_sequencer.sv]
// mtsu_sequencer: operation decode, word counters, memory addressing, result register
// drives mtsu_state_ram and mtsu_word_unit; uses mtsu_pkg

module mtsu_sequencer #(
  parameter int STATE_SIZE   = 624,
  parameter int SHIFT_OFFSET = 397,
  parameter int AW           = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [mtsu_pkg::FUNC_W-1:0]  in_func,
  input  logic [mtsu_pkg::DATA_W-1:0]  in_seed,
  input  logic [mtsu_pkg::INDEX_W-1:0] in_index,
  input  logic [mtsu_pkg::DATA_W-1:0]  default_seed,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [mtsu_pkg::DATA_W-1:0]  out_tdata,
  output mtsu_pkg::unit_ctrl_t         ctrl,
  output logic [AW-1:0]                unit_idx,
  output logic [mtsu_pkg::DATA_W-1:0]  seed_base,
  output logic                         ram_we,
  output logic [AW-1:0]                ram_waddr,
  output logic                         ram_re,
  output logic [AW-1:0]                ram_ra0,
  output logic [AW-1:0]                ram_ra1,
  input  logic [mtsu_pkg::DATA_W-1:0]  ram_rd0
);

  localparam logic [AW-1:0] LAST      = AW'(STATE_SIZE - 1);
  localparam logic [AW-1:0] FAR_START = AW'(SHIFT_OFFSET % STATE_SIZE);
  localparam int            RNG_W     = mtsu_pkg::INDEX_W + 1;

  mtsu_pkg::seq_state_t state_r, state_nxt;

  logic [AW-1:0]               k_r, k_nxt;
  logic [AW-1:0]               f_r, f_nxt;
  logic [AW-1:0]               ck_r, ck_nxt;
  logic                        cv_r, cv_nxt;
  logic [AW-1:0]               k_inc;
  logic [AW-1:0]               f_inc;
  logic [mtsu_pkg::DATA_W-1:0] seed_r;
  logic [AW-1:0]               idx_r;
  logic                        rng_r;
  logic                        out_valid_r;
  logic [mtsu_pkg::DATA_W-1:0] out_data_r;
  logic                        accept;
  logic                        ld_out;

  assign in_tready = (state_r == mtsu_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign k_inc     = (k_r == LAST) ? '0 : k_r + 1'b1;
  assign f_inc     = (f_r == LAST) ? '0 : f_r + 1'b1;
  assign unit_idx  = k_r;
  assign seed_base = seed_r;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    f_nxt     = f_r;
    ck_nxt    = ck_r;
    cv_nxt    = cv_r;
    ctrl      = '0;
    ram_we    = 1'b0;
    ram_waddr = k_r;
    ram_re    = 1'b0;
    ram_ra0   = k_inc;
    ram_ra1   = f_r;
    ld_out    = 1'b0;
    unique case (state_r)
      mtsu_pkg::ST_IDLE: begin
        if (accept) begin
          case (mtsu_pkg::func_t'(in_func))
            mtsu_pkg::FUNC_SEED: begin
              state_nxt = mtsu_pkg::ST_SEED;
              k_nxt     = '0;
            end
            mtsu_pkg::FUNC_TWIST: state_nxt = mtsu_pkg::ST_TW_PRE;
            mtsu_pkg::FUNC_READ:  state_nxt = mtsu_pkg::ST_RD_ISSUE;
            default: ;
          endcase
        end
      end
      mtsu_pkg::ST_SEED: begin
        ctrl.seed_step  = 1'b1;
        ctrl.seed_first = (k_r == '0);
        ram_we          = 1'b1;
        ram_waddr       = k_r;
        k_nxt           = k_inc;
        if (k_r == LAST) begin
          state_nxt = mtsu_pkg::ST_IDLE;
        end
      end
      mtsu_pkg::ST_TW_PRE: begin
        // fetch word 0 to seed the current-word register
        ram_re    = 1'b1;
        ram_ra0   = '0;
        k_nxt     = '0;
        f_nxt     = FAR_START;
        cv_nxt    = 1'b0;
        state_nxt = mtsu_pkg::ST_TW_RUN;
      end
      mtsu_pkg::ST_TW_RUN: begin
        // issue reads for word k, write word k-1
        ram_re           = 1'b1;
        ram_ra0          = k_inc;
        ram_ra1          = f_r;
        ctrl.twist_comp  = cv_r;
        ctrl.twist_prime = !cv_r;
        ram_we           = cv_r;
        ram_waddr        = ck_r;
        ck_nxt           = k_r;
        cv_nxt           = 1'b1;
        k_nxt            = k_inc;
        f_nxt            = f_inc;
        if (k_r == LAST) begin
          state_nxt = mtsu_pkg::ST_TW_END;
        end
      end
      mtsu_pkg::ST_TW_END: begin
        ctrl.twist_comp = 1'b1;
        ram_we          = 1'b1;
        ram_waddr       = ck_r;
        state_nxt       = mtsu_pkg::ST_IDLE;
      end
      mtsu_pkg::ST_RD_ISSUE: begin
        ram_re    = 1'b1;
        ram_ra0   = idx_r;
        state_nxt = mtsu_pkg::ST_RD_DATA;
      end
      mtsu_pkg::ST_RD_DATA: begin
        if (!out_valid_r || out_tready) begin
          ld_out    = 1'b1;
          state_nxt = mtsu_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mtsu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mtsu_pkg::ST_IDLE;
      k_r         <= '0;
      f_r         <= '0;
      ck_r        <= '0;
      cv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      f_r     <= f_nxt;
      ck_r    <= ck_nxt;
      cv_r    <= cv_nxt;
      if (ld_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      seed_r <= (in_seed != '0) ? in_seed : default_seed;
      idx_r  <= in_index[AW-1:0];
      rng_r  <= (RNG_W'(in_index) < RNG_W'(STATE_SIZE));
    end
    if (ld_out) begin
      out_data_r <= rng_r ? ram_rd0 : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[sv/mt19937_state_seed_and_twist_unit.sv]
// mt19937_state_seed_and_twist_unit: top level of the mt19937 state store
// instantiates mtsu_sequencer, mtsu_word_unit and mtsu_state_ram; uses mtsu_pkg
//
//   channel  role     ports         payload
//   in_      slave    tvalid/tready tuser = func, tdata = seed_value, word_index
//   out_     master   tvalid/tready tdata = state_word
//   cfg_     apb      psel/penable  register 0 default_seed at byte address 0
//
// a seed transfer occupies the block until all STATE_SIZE words are written, one word written per cycle
// a twist transfer runs one prefetch, then one word per cycle, then
// one final write; the single write port of the state memory sets the pace
// a read passes ST_RD_ISSUE and ST_RD_DATA to reach the output register, waiting while out_ is stalled
// in_tready is high only when idle; a waiting result does not block seed or twist
// reset clears control and sets default_seed to 29; state words stay undefined

module mt19937_state_seed_and_twist_unit #(
  parameter int STATE_SIZE   = 624,
  parameter int SHIFT_OFFSET = 397
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mtsu_pkg::IN_TDATA_W-1:0]  in_tdata,   // [31:0] seed_value, [41:32] word_index
  input  logic [mtsu_pkg::FUNC_W-1:0]      in_tuser,   // [1:0] func
  // result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mtsu_pkg::DATA_W-1:0]      out_tdata,  // [31:0] state_word
  // configuration port
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [mtsu_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [mtsu_pkg::DATA_W-1:0]      cfg_pwdata,
  output logic [mtsu_pkg::DATA_W-1:0]      cfg_prdata,
  output logic                             cfg_pready
);

  localparam int AW = $clog2(STATE_SIZE);

  logic [mtsu_pkg::DATA_W-1:0] default_seed_r;
  logic                        cfg_wr;
  logic                        cfg_sel_seed;

  mtsu_pkg::unit_ctrl_t        ctrl;
  logic [AW-1:0]               unit_idx;
  logic [mtsu_pkg::DATA_W-1:0] seed_base;
  logic [mtsu_pkg::DATA_W-1:0] wdata;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic                        ram_re;
  logic [AW-1:0]               ram_ra0;
  logic [AW-1:0]               ram_ra1;
  logic [mtsu_pkg::DATA_W-1:0] ram_rd0;
  logic [mtsu_pkg::DATA_W-1:0] ram_rd1;

  // register decode: word index is the address above the byte offset
  assign cfg_pready   = 1'b1;
  assign cfg_sel_seed = (cfg_paddr[2] == mtsu_pkg::REG_DEFAULT_SEED);
  assign cfg_wr       = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata   = cfg_sel_seed ? default_seed_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_seed_r <= mtsu_pkg::DEFAULT_SEED_RST;
    end else if (cfg_wr && cfg_sel_seed) begin
      default_seed_r <= cfg_pwdata;
    end
  end

  // operation decode, counters and result register
  mtsu_sequencer #(
    .STATE_SIZE   (STATE_SIZE),
    .SHIFT_OFFSET (SHIFT_OFFSET),
    .AW           (AW)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_func      (in_tuser),
    .in_seed      (in_tdata[31:0]),
    .in_index     (in_tdata[41:32]),
    .default_seed (default_seed_r),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .ctrl         (ctrl),
    .unit_idx     (unit_idx),
    .seed_base    (seed_base),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_re       (ram_re),
    .ram_ra0      (ram_ra0),
    .ram_ra1      (ram_ra1),
    .ram_rd0      (ram_rd0)
  );

  // one new state word per cycle, seed or twist
  mtsu_word_unit #(
    .AW (AW)
  ) u_unit (
    .clk       (clk),
    .ctrl      (ctrl),
    .idx       (unit_idx),
    .seed_base (seed_base),
    .rd0       (ram_rd0),
    .rd1       (ram_rd1),
    .wdata     (wdata)
  );

  // state words
  mtsu_state_ram #(
    .DEPTH (STATE_SIZE),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wdata),
    .re    (ram_re),
    .ra0   (ram_ra0),
    .ra1   (ram_ra1),
    .rd0   (ram_rd0),
    .rd1   (ram_rd1)
  );

endmodule

[sv/mtsu_checker.sv]
// mtsu_checker: port-level assertions for mt19937_state_seed_and_twist_unit
// bound to the top level below; uses mtsu_pkg

module mtsu_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [mtsu_pkg::FUNC_W-1:0]      in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [mtsu_pkg::DATA_W-1:0]      out_tdata
);

  logic in_xfer;
  assign in_xfer = in_tvalid && in_tready;

  // seed walks the whole state, so the block is busy right after
  a_seed_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_tuser == mtsu_pkg::FUNC_SEED) |=> !in_tready)
    else $error("in_tready high right after a seed transfer");

  // read holds the input side until its result is registered
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_tuser == mtsu_pkg::FUNC_READ) |=> !in_tready)
    else $error("in_tready high right after a read transfer");

  // only a read brings a result, and never in the next cycle
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !$rose(out_tvalid))
    else $error("result appeared one cycle after an input transfer");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

endmodule

bind mt19937_state_seed_and_twist_unit mtsu_checker u_mtsu_checker (.*);
